// ===== sv/assert_macros.svh =====
// assert_macros.svh: concurrent assertion wrappers for the button classifier RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// check sampled on clk, disabled while the active-low reset is asserted
`define ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// check sampled on clk, active during reset too
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== sv/bpc_pkg.sv =====
// bpc_pkg: shared types and constants for the button press classifier.
// No dependencies; used by bpc_step and button_press_classifier.
`timescale 1ns / 1ps

package bpc_pkg;

  localparam int unsigned CntW   = 8;
  localparam int unsigned PatW   = 3;
  localparam int unsigned CmdW   = 7;
  localparam int unsigned SleepW = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // register indexes on the config port
  localparam logic [CfgIdxW-1:0] RegShortPress = 2'd0;
  localparam logic [CfgIdxW-1:0] RegLongPress  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegRepeat     = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSleepLoad  = 2'd3;

  // register reset values
  localparam logic [CntW-1:0]   ShortPressRst = 8'd2;
  localparam logic [CntW-1:0]   LongPressRst  = 8'd40;
  localparam logic [CntW-1:0]   RepeatRst     = 8'd10;
  localparam logic [SleepW-1:0] SleepLoadRst  = 16'd1000;

  typedef struct packed {
    logic [CntW-1:0]   short_press_ticks;
    logic [CntW-1:0]   long_press_ticks;
    logic [CntW-1:0]   repeat_ticks;
    logic [SleepW-1:0] sleep_reload;
  } cfg_t;

  typedef struct packed {
    logic [CntW-1:0]   press_count;
    logic [PatW-1:0]   last_pattern;
    logic [CmdW-1:0]   pending_command;
    logic [SleepW-1:0] sleep_count;
  } state_t;

endpackage

// ===== sv/bpc_step.sv =====
// bpc_step: next-state and result logic for one word of the button classifier.
// Depends on bpc_pkg (cfg_t, state_t, widths).
`timescale 1ns / 1ps

module bpc_step (
  input  bpc_pkg::cfg_t                 cfg_i,
  input  bpc_pkg::state_t               state_i,
  input  logic                          tick_i,
  input  logic [bpc_pkg::PatW-1:0]      button_levels_i,
  input  logic                          wake_i,
  input  logic                          take_command_i,
  output bpc_pkg::state_t               state_o,
  output logic [bpc_pkg::CmdW-1:0]      command_o
);

  logic [bpc_pkg::CntW-1:0] cnt_inc;
  logic [bpc_pkg::CntW:0]   upper;      // signed long - repeat
  logic                     short_hit;
  logic [bpc_pkg::CmdW-1:0] cmd_tick;

  assign cnt_inc = state_i.press_count + 8'd1;
  assign upper   = {1'b0, cfg_i.long_press_ticks} - {1'b0, cfg_i.repeat_ticks};
  assign short_hit = (state_i.press_count > cfg_i.short_press_ticks) &&
                     ($signed({1'b0, state_i.press_count}) < $signed(upper));

  always_comb begin
    state_o  = state_i;
    cmd_tick = state_i.pending_command;

    // button pattern tracking
    if (tick_i) begin
      if (button_levels_i != '0) begin
        if (button_levels_i == state_i.last_pattern) begin
          state_o.press_count = cnt_inc;
          if (cnt_inc == cfg_i.long_press_ticks) begin
            cmd_tick = {state_i.last_pattern, 4'b0000};
            state_o.press_count = cfg_i.long_press_ticks - cfg_i.repeat_ticks;
          end
        end else begin
          state_o.last_pattern = button_levels_i;
        end
      end else begin
        if (short_hit) begin
          cmd_tick = {4'b0000, state_i.last_pattern};
        end
        state_o.press_count = '0;
      end
      // sleep countdown saturates at zero
      if (state_i.sleep_count != '0) begin
        state_o.sleep_count = state_i.sleep_count - 16'd1;
      end
    end
    if (wake_i) begin
      state_o.sleep_count = cfg_i.sleep_reload;
    end

    // report before clearing on take
    state_o.pending_command = take_command_i ? '0 : cmd_tick;
  end

  assign command_o = cmd_tick;

endmodule

// ===== sv/button_press_classifier.sv =====
// Button press classifier: short, long and autorepeat detection on three buttons.
// The result word of an accepted input word is written to the output register in the next cycle.
// Throughput: one word per cycle while the output is not stalled; the whole state update is one combinational pass.
// Input is taken whenever the output register is empty or being drained.
// Reset (rst_ni low, async): state cleared, registers to defaults, sleep counter to 1000.
// Depends on bpc_pkg, bpc_step and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module button_press_classifier (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // config write port
  input  logic                             cfg_we_i,
  input  logic [bpc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [bpc_pkg::CfgDataW-1:0]     cfg_wdata_i,
  // input channel
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             tick_i,
  input  logic [bpc_pkg::PatW-1:0]         button_levels_i,
  input  logic                             wake_i,
  input  logic                             take_command_i,
  // output channel
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [bpc_pkg::CmdW-1:0]         command_o,
  output logic [bpc_pkg::SleepW-1:0]       sleep_remaining_o
);

  bpc_pkg::cfg_t   cfg_q;
  bpc_pkg::state_t state_q, state_d;
  logic [bpc_pkg::CmdW-1:0]   cmd_d, cmd_q;
  logic                       out_valid_q;
  logic                       accept;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_press_ticks <= bpc_pkg::ShortPressRst;
      cfg_q.long_press_ticks  <= bpc_pkg::LongPressRst;
      cfg_q.repeat_ticks      <= bpc_pkg::RepeatRst;
      cfg_q.sleep_reload      <= bpc_pkg::SleepLoadRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bpc_pkg::RegShortPress: cfg_q.short_press_ticks <= cfg_wdata_i[bpc_pkg::CntW-1:0];
        bpc_pkg::RegLongPress:  cfg_q.long_press_ticks  <= cfg_wdata_i[bpc_pkg::CntW-1:0];
        bpc_pkg::RegRepeat:     cfg_q.repeat_ticks      <= cfg_wdata_i[bpc_pkg::CntW-1:0];
        bpc_pkg::RegSleepLoad:  cfg_q.sleep_reload      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // next-state logic
  bpc_step u_step (
    .cfg_i           (cfg_q),
    .state_i         (state_q),
    .tick_i          (tick_i),
    .button_levels_i (button_levels_i),
    .wake_i          (wake_i),
    .take_command_i  (take_command_i),
    .state_o         (state_d),
    .command_o       (cmd_d)
  );

  // classifier state, updated on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.press_count     <= '0;
      state_q.last_pattern    <= '0;
      state_q.pending_command <= '0;
      state_q.sleep_count     <= bpc_pkg::SleepLoadRst;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign command_o         = cmd_q;
  assign sleep_remaining_o = state_q.sleep_count;

  // checks
  `ASSERT_RST(a_take_clears, clk_i, rst_ni,
    (accept && take_command_i) |=> (state_q.pending_command == '0),
    "pending command not cleared after take")
  `ASSERT_RST(a_accept_gives_result, clk_i, rst_ni,
    accept |=> out_valid_o,
    "accepted word produced no result")
  `ASSERT_RST(a_sleep_dec, clk_i, rst_ni,
    (accept && tick_i && !wake_i && (state_q.sleep_count != '0))
      |=> (state_q.sleep_count == $past(state_q.sleep_count) - 16'd1),
    "sleep counter did not decrement on tick")
  `ASSERT_RST(a_no_tick_count_hold, clk_i, rst_ni,
    (accept && !tick_i) |=> $stable(state_q.press_count),
    "press count changed without a tick")

endmodule
